// ===== design/vgacc_pkg.sv =====
// ----------------------------------------------------------------------------
// vgacc_pkg: shared types and constants of the visibility grid accumulator
// Field widths, word layouts, sequencer states and arithmetic constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vgacc_pkg;

    localparam int GRID_SIZE_DEF = 256;

    // Field widths
    localparam int CELL_W    = 48;
    localparam int SUM_W     = 48;
    localparam int COORD_W   = 32;
    localparam int VIS_W     = 32;
    localparam int FREQ_W    = 40;
    localparam int IDX_OUT_W = 8;

    // Stream words: input tdata 216 bits, output tdata 160 bits
    localparam int IN_DATA_W  = 4 * COORD_W + VIS_W + FREQ_W + 2 * IDX_OUT_W;
    localparam int OUT_DATA_W = 2 * IDX_OUT_W + 3 * SUM_W;

    // Digit-serial multiplier: 16-bit digits, 80-bit digit shift register
    localparam int DIGIT_W     = 16;
    localparam int MB_W        = 80;
    localparam int FREQ_DIGITS = 3;
    localparam int PROD_DIGITS = 5;
    localparam int MAG_FREQ_W  = 72;

    // Position scaling: divide by c * 2^57
    localparam int FRAC_SHIFT = 57;
    localparam int REM_W      = 29;
    localparam logic [REM_W-1:0] LIGHT_SPEED = 29'd299792458;

    localparam logic [SUM_W-1:0] SUM_S_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_S_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [SUM_W-1:0] SUM_U_MAX = {SUM_W{1'b1}};

    typedef enum logic {
        OP_ACCUM = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MLOAD,
        ST_MUL,
        ST_DIVLD,
        ST_DIV,
        ST_INDEX,
        ST_WMUL,
        ST_MRD,
        ST_MUPD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                 in_grid;
        logic [IDX_OUT_W-1:0] row;
        logic [IDX_OUT_W-1:0] col;
        logic [SUM_W-1:0]     sum_real;
        logic [SUM_W-1:0]     sum_imag;
        logic [SUM_W-1:0]     sum_weight;
    } t_result;

endpackage

// ===== design/visibility_grid_accumulator.sv =====
// ----------------------------------------------------------------------------
// visibility_grid_accumulator: nearest-neighbor visibility gridding
// Throughput: one word at a time; a new word is taken only once the last
//   result is in the output register, which may wait on i_m_tready.
// Rate is set by the shared 16-bit-digit multiplier, which also divides by c
//   through a reciprocal.
// Reset: synchronous; then a pass clears all 2^(2*clog2(GRID_SIZE)) cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module visibility_grid_accumulator #(
    parameter int GRID_SIZE = vgacc_pkg::GRID_SIZE_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // cell_size, unsigned Q0.48
    input  logic                             i_cfg_wr_en,
    input  logic [vgacc_pkg::CELL_W-1:0]     i_cfg_wr_data,
    // Input stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata, low bit up: u_coord[31:0], v_coord[63:32], vis_real[95:64],
    // vis_imag[127:96], vis_weight[159:128], frequency_hz[199:160],
    // read_row[207:200], read_col[215:208]
    input  logic [vgacc_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // tuser: operation[0]
    input  logic [0:0]                       i_s_tuser,
    // Output stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata, low bit up: cell_row[7:0], cell_col[15:8], sum_real[63:16],
    // sum_imag[111:64], sum_weight[159:112]
    output logic [vgacc_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // tuser: in_grid[0]
    output logic [0:0]                       o_m_tuser
);
    import vgacc_pkg::*;

    // Index width of one grid axis, and of the stored row/column
    localparam int IW   = $clog2(GRID_SIZE);
    localparam int XW   = (IW > IDX_OUT_W) ? IW : IDX_OUT_W;
    localparam int MAW  = 2 * IW;
    localparam int MEM_DEPTH = 1 << MAW;
    localparam int MEM_W = 3 * SUM_W;
    // cell_size * GRID_SIZE, and the full product |coord| * freq * that
    localparam int CGW  = CELL_W + IW;
    localparam int PW   = MAG_FREQ_W + CGW;
    // Quotient bits that decide the index; larger quotients are off the grid
    localparam int TW   = $clog2(GRID_SIZE + 2) + 1;
    localparam int HIW  = PW - FRAC_SHIFT - TW;
    // Divide by c as a multiply by ceil(2^RSH / c): exact for every dividend
    // below c * 2^TW, which covers everything that can land on the grid
    localparam int XQW  = REM_W + TW;
    localparam int RSH  = XQW + REM_W;
    localparam int RECIP_W = XQW + 1;
    localparam int RECIP_DIGITS = (RECIP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int RDW  = RECIP_DIGITS * DIGIT_W;
    localparam logic [RDW-1:0] RECIP =
        RDW'(((128'd1 << RSH) + 128'(LIGHT_SPEED) - 128'd1) / 128'(LIGHT_SPEED));
    localparam int IXW  = TW + 2;
    localparam int CNTW = $clog2(PROD_DIGITS + 1);
    localparam int HALF = GRID_SIZE / 2;

    // ------------------------------------------------------------------
    // Input word fields
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]   w_in_u;
    logic [COORD_W-1:0]   w_in_v;
    logic [VIS_W-1:0]     w_in_real;
    logic [VIS_W-1:0]     w_in_imag;
    logic [VIS_W-1:0]     w_in_weight;
    logic [FREQ_W-1:0]    w_in_freq;
    logic [IDX_OUT_W-1:0] w_in_rrow;
    logic [IDX_OUT_W-1:0] w_in_rcol;
    t_op                  w_in_op;

    assign w_in_u      = i_s_tdata[31:0];
    assign w_in_v      = i_s_tdata[63:32];
    assign w_in_real   = i_s_tdata[95:64];
    assign w_in_imag   = i_s_tdata[127:96];
    assign w_in_weight = i_s_tdata[159:128];
    assign w_in_freq   = i_s_tdata[199:160];
    assign w_in_rrow   = i_s_tdata[207:200];
    assign w_in_rcol   = i_s_tdata[215:208];
    assign w_in_op     = t_op'(i_s_tuser[0]);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [COORD_W-1:0]   r_u, n_u;
    logic [COORD_W-1:0]   r_v, n_v;
    logic [VIS_W-1:0]     r_real, n_real;
    logic [VIS_W-1:0]     r_imag, n_imag;
    logic [VIS_W-1:0]     r_weight, n_weight;
    logic [FREQ_W-1:0]    r_freq, n_freq;
    logic [XW-1:0]        r_row, n_row;
    logic [XW-1:0]        r_col, n_col;
    logic                 r_coord, n_coord;
    logic                 r_phase, n_phase;
    logic [PW-1:0]        r_acc, n_acc;
    logic [CGW-1:0]       r_a, n_a;
    logic [MB_W-1:0]      r_mb, n_mb;
    logic [CNTW-1:0]      r_cnt, n_cnt;
    logic                 r_sat, n_sat;
    logic [TW-1:0]        r_t, n_t;
    logic [SUM_W-1:0]     r_wr, n_wr;
    logic [SUM_W-1:0]     r_wi, n_wi;
    logic [MAW-1:0]       r_clr_addr, n_clr_addr;
    t_result              r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;
    logic [CGW-1:0]       r_cell_g;
    logic [MEM_W-1:0]     r_rd_data;
    logic [MEM_W-1:0]     r_grid_mem [0:MEM_DEPTH-1];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic                   w_accept;
    logic                   w_in_rd_ok;
    logic [CGW-1:0]         w_cell_g_new;
    logic [COORD_W-1:0]     w_coord;
    logic [COORD_W-1:0]     w_mag;
    logic [DIGIT_W-1:0]     w_digit;
    logic [CGW+DIGIT_W-1:0] w_pp;
    logic [PW-1:0]          w_acc_next;
    logic [HIW-1:0]         w_div_hi;
    logic                   w_div_sat;
    logic [XQW-1:0]         w_div_x;
    logic [TW:0]            w_t1;
    logic [TW:0]            w_rnd;
    logic [IXW-1:0]         w_idx;
    logic                   w_inside;
    logic signed [64:0]     w_prod_re;
    logic signed [64:0]     w_prod_im;
    logic [SUM_W:0]         w_s_re;
    logic [SUM_W:0]         w_s_im;
    logic [SUM_W:0]         w_s_w;
    logic [SUM_W-1:0]       w_new_re;
    logic [SUM_W-1:0]       w_new_im;
    logic [SUM_W-1:0]       w_new_w;
    logic [MAW-1:0]         w_addr;
    logic                   w_mem_we;
    logic [MAW-1:0]         w_mem_waddr;
    logic [MEM_W-1:0]       w_mem_wdata;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Reads beyond the grid are answered without touching memory
    assign w_in_rd_ok = ((XW+1)'(w_in_rrow) < (XW+1)'(GRID_SIZE)) &&
                        ((XW+1)'(w_in_rcol) < (XW+1)'(GRID_SIZE));

    // Fold the grid size into the cell size once, at the register write
    assign w_cell_g_new = CGW'(i_cfg_wr_data) * CGW'(GRID_SIZE);

    // Coordinate under work: u gives the row, v the column
    assign w_coord = r_coord ? r_v : r_u;
    assign w_mag   = w_coord[COORD_W-1] ? (COORD_W'(0) - w_coord) : w_coord;

    // Horner step: shift the sum one digit, add operand times next digit
    assign w_digit    = r_mb[MB_W-1 -: DIGIT_W];
    assign w_pp       = r_a * w_digit;
    assign w_acc_next = (r_acc << DIGIT_W) + PW'(w_pp);

    // Product >> 57, then divide by c. A high part of c or more means a
    // quotient of at least 2^TW, which is always off the grid; below that
    // the dividend fits XQW bits and goes through the reciprocal multiply.
    assign w_div_hi   = r_acc[PW-1:FRAC_SHIFT+TW];
    assign w_div_sat  = (w_div_hi >= HIW'(LIGHT_SPEED));
    assign w_div_x    = r_acc[FRAC_SHIFT+XQW-1:FRAC_SHIFT];

    // Round half away from zero, then offset by the grid center
    assign w_t1  = {1'b0, r_t} + (TW+1)'(1);
    assign w_rnd = w_t1 >> 1;
    assign w_idx = w_coord[COORD_W-1] ? (IXW'(HALF) - IXW'(w_rnd))
                                      : (IXW'(HALF) + IXW'(w_rnd));
    assign w_inside = !r_sat && !w_idx[IXW-1] && (w_idx < IXW'(GRID_SIZE));

    // Weighted visibility, Q31.16 floored toward minus infinity
    assign w_prod_re = $signed(r_real) * $signed({1'b0, r_weight});
    assign w_prod_im = $signed(r_imag) * $signed({1'b0, r_weight});

    // Saturating cell update
    assign w_s_re = {r_rd_data[SUM_W-1], r_rd_data[SUM_W-1:0]} + {r_wr[SUM_W-1], r_wr};
    assign w_s_im = {r_rd_data[2*SUM_W-1], r_rd_data[2*SUM_W-1:SUM_W]} +
                    {r_wi[SUM_W-1], r_wi};
    assign w_s_w  = {1'b0, r_rd_data[3*SUM_W-1:2*SUM_W]} + (SUM_W+1)'(r_weight);

    assign w_new_re = (w_s_re[SUM_W] != w_s_re[SUM_W-1]) ?
                      (w_s_re[SUM_W] ? SUM_S_MIN : SUM_S_MAX) : w_s_re[SUM_W-1:0];
    assign w_new_im = (w_s_im[SUM_W] != w_s_im[SUM_W-1]) ?
                      (w_s_im[SUM_W] ? SUM_S_MIN : SUM_S_MAX) : w_s_im[SUM_W-1:0];
    assign w_new_w  = w_s_w[SUM_W] ? SUM_U_MAX : w_s_w[SUM_W-1:0];

    // Grid memory: row-major cell address, one word holds all three sums
    assign w_addr      = {r_row[IW-1:0], r_col[IW-1:0]};
    assign w_mem_we    = (r_state == ST_CLEAR) ||
                         ((r_state == ST_MUPD) && (r_op == OP_ACCUM));
    assign w_mem_waddr = (r_state == ST_CLEAR) ? r_clr_addr : w_addr;
    assign w_mem_wdata = (r_state == ST_CLEAR) ? '0 : {w_new_w, w_new_im, w_new_re};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_grid_mem[w_mem_waddr] <= w_mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_grid_mem[w_addr];
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_in_op == OP_READ) begin
                        n_state = w_in_rd_ok ? ST_MRD : ST_DONE;
                    end else begin
                        n_state = ST_MLOAD;
                    end
                end
            end
            ST_MLOAD: n_state = ST_MUL;
            ST_MUL: begin
                if ((r_cnt == CNTW'(1)) && r_phase) begin
                    n_state = ST_DIVLD;
                end
            end
            ST_DIVLD: n_state = w_div_sat ? ST_INDEX : ST_DIV;
            ST_DIV: begin
                if (r_cnt == CNTW'(1)) begin
                    n_state = ST_INDEX;
                end
            end
            ST_INDEX: begin
                if (!w_inside) begin
                    n_state = ST_DONE;
                end else if (!r_coord) begin
                    n_state = ST_MLOAD;
                end else begin
                    n_state = ST_WMUL;
                end
            end
            ST_WMUL: n_state = ST_MRD;
            ST_MRD:  n_state = ST_MUPD;
            ST_MUPD: n_state = ST_DONE;
            ST_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and output register updates
    // ------------------------------------------------------------------
    always_comb begin
        n_op        = r_op;
        n_u         = r_u;
        n_v         = r_v;
        n_real      = r_real;
        n_imag      = r_imag;
        n_weight    = r_weight;
        n_freq      = r_freq;
        n_row       = r_row;
        n_col       = r_col;
        n_coord     = r_coord;
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_a         = r_a;
        n_mb        = r_mb;
        n_cnt       = r_cnt;
        n_sat       = r_sat;
        n_t         = r_t;
        n_wr        = r_wr;
        n_wi        = r_wi;
        n_clr_addr  = r_clr_addr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the held word once it is taken
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + MAW'(1);
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_op     = w_in_op;
                    n_u      = w_in_u;
                    n_v      = w_in_v;
                    n_real   = w_in_real;
                    n_imag   = w_in_imag;
                    n_weight = w_in_weight;
                    n_freq   = w_in_freq;
                    n_row    = XW'(w_in_rrow);
                    n_col    = XW'(w_in_rcol);
                    n_coord  = 1'b0;
                    // Out-of-range read: echo the request, no sums
                    n_res            = '0;
                    n_res.row        = w_in_rrow;
                    n_res.col        = w_in_rcol;
                end
            end
            ST_MLOAD: begin
                // First pass: |coord| * frequency, three frequency digits
                n_a     = CGW'(w_mag);
                n_mb    = {8'd0, r_freq, 32'd0};
                n_acc   = '0;
                n_cnt   = CNTW'(FREQ_DIGITS);
                n_phase = 1'b0;
            end
            ST_MUL: begin
                n_acc = w_acc_next;
                n_mb  = r_mb << DIGIT_W;
                n_cnt = r_cnt - CNTW'(1);
                if ((r_cnt == CNTW'(1)) && !r_phase) begin
                    // Second pass: that product times cell_size * GRID_SIZE
                    n_phase = 1'b1;
                    n_a     = r_cell_g;
                    n_mb    = {8'd0, w_acc_next[MAG_FREQ_W-1:0]};
                    n_acc   = '0;
                    n_cnt   = CNTW'(PROD_DIGITS);
                end
            end
            ST_DIVLD: begin
                // Third pass: dividend times the reciprocal of c
                n_sat = w_div_sat;
                n_a   = CGW'(w_div_x);
                n_mb  = {RECIP, {(MB_W-RDW){1'b0}}};
                n_acc = '0;
                n_t   = '0;
                n_cnt = CNTW'(RECIP_DIGITS);
            end
            ST_DIV: begin
                n_acc = w_acc_next;
                n_mb  = r_mb << DIGIT_W;
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    n_t = w_acc_next[RSH+TW-1:RSH];
                end
            end
            ST_INDEX: begin
                if (!w_inside) begin
                    n_res = '0;
                end else if (!r_coord) begin
                    n_row   = XW'(w_idx);
                    n_coord = 1'b1;
                end else begin
                    n_col = XW'(w_idx);
                end
            end
            ST_WMUL: begin
                n_wr = w_prod_re[63:16];
                n_wi = w_prod_im[63:16];
            end
            ST_MRD: begin
            end
            ST_MUPD: begin
                n_res.in_grid = 1'b1;
                n_res.row     = r_row[IDX_OUT_W-1:0];
                n_res.col     = r_col[IDX_OUT_W-1:0];
                if (r_op == OP_ACCUM) begin
                    n_res.sum_real   = w_new_re;
                    n_res.sum_imag   = w_new_im;
                    n_res.sum_weight = w_new_w;
                end else begin
                    n_res.sum_real   = r_rd_data[SUM_W-1:0];
                    n_res.sum_imag   = r_rd_data[2*SUM_W-1:SUM_W];
                    n_res.sum_weight = r_rd_data[3*SUM_W-1:2*SUM_W];
                end
            end
            ST_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cell_g    <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_cell_g <= w_cell_g_new;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_u      <= n_u;
        r_v      <= n_v;
        r_real   <= n_real;
        r_imag   <= n_imag;
        r_weight <= n_weight;
        r_freq   <= n_freq;
        r_row    <= n_row;
        r_col    <= n_col;
        r_coord  <= n_coord;
        r_phase  <= n_phase;
        r_acc    <= n_acc;
        r_a      <= n_a;
        r_mb     <= n_mb;
        r_cnt    <= n_cnt;
        r_sat    <= n_sat;
        r_t      <= n_t;
        r_wr     <= n_wr;
        r_wi     <= n_wi;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.sum_weight, r_out.sum_imag, r_out.sum_real,
                         r_out.col, r_out.row};
    assign o_m_tuser  = r_out.in_grid;

`ifndef SYNTH
    // Reciprocal quotient never reaches past the index bits
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIV) && (r_cnt == CNTW'(1))) |->
        ((w_acc_next >> (RSH + TW)) == '0))
        else $error("quotient by c exceeded the index range");

    // Only cells inside the grid are ever updated or read
    a_cell_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUPD) |->
        (((XW+1)'(r_row) < (XW+1)'(GRID_SIZE)) && ((XW+1)'(r_col) < (XW+1)'(GRID_SIZE))))
        else $error("memory access outside the grid");

    // A dropped or rejected word carries no sums
    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.in_grid) |->
        ((r_out.sum_real == '0) && (r_out.sum_imag == '0) && (r_out.sum_weight == '0)))
        else $error("off-grid result with nonzero sums");

    // Weight sums never decrease on accumulate
    a_weight_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_MUPD) && (r_op == OP_ACCUM)) |->
        (w_new_w >= r_rd_data[3*SUM_W-1:2*SUM_W]))
        else $error("weight sum decreased");

    // An accepted word always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ST_IDLE))
        else $error("accepted word left the sequencer idle");
`endif

endmodule
